// ===== rtl/core/gpool_pkg.sv =====
`timescale 1ns / 1ps

package gpool_pkg;

    // default sizing
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_FACTOR = 16;

    // fixed field widths
    localparam int COST_W         = 8;
    localparam int COL_W          = 12;
    localparam int ROW_W          = 16;
    localparam int FACTOR_FIELD_W = 5;
    localparam int WIDTH_FIELD_W  = 13;
    localparam int HEIGHT_W       = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 2;

    // register reset values
    localparam int FACTOR_RESET = 2;
    localparam int WIDTH_RESET  = 4096;
    localparam int HEIGHT_RESET = 4096;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BLOCK_FACTOR = 2'd0,
        REG_MAP_WIDTH    = 2'd1,
        REG_MAP_HEIGHT   = 2'd2,
        REG_MIN_MODE     = 2'd3
    } cfg_reg_t;

    // position flags of the cell under the input counters
    typedef struct packed {
        logic first_col;   // first cell of a block segment in this row
        logic seg_end;     // last cell of a block segment in this row
        logic first_row;   // first row of a block row
        logic block_done;  // last row of a block row
        logic last;        // last cell of the frame
    } pos_flags_t;

endpackage

// ===== rtl/core/gpool_if.sv =====
`timescale 1ns / 1ps

interface gpool_cell_if;
    import gpool_pkg::*;

    logic              valid;
    logic              ready;
    logic [COST_W-1:0] cell_cost;

    modport source (output valid, output cell_cost, input ready);
    modport sink   (input valid, input cell_cost, output ready);
endinterface

interface gpool_result_if;
    import gpool_pkg::*;

    logic              valid;
    logic              ready;
    logic [COST_W-1:0] pooled_cost;
    logic [COL_W-1:0]  out_col;
    logic [ROW_W-1:0]  out_row;
    logic              last_cell;

    modport source (output valid, output pooled_cost, output out_col, output out_row,
                    output last_cell, input ready);
    modport sink   (input valid, input pooled_cost, input out_col, input out_row,
                    input last_cell, output ready);
endinterface

// ===== rtl/core/grid_block_min_max_pool.sv =====
`timescale 1ns / 1ps

// Block min/max pooling of a raster stream of 8-bit cell costs. One cell is taken
// every clock while the result side keeps up; the cell closing a block is held in the
// work stage, and its reduced value moves into the output register when that is free.
// The rate is set by the running block value, which is folded with each new cell
// combinationally, and by the column line store, which does one read and one write a
// clock. The line store has no clearing pass and needs no time after reset. Any
// register write restarts the frame at column 0, row 0; writes belong between frames.
module grid_block_min_max_pool
    import gpool_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = DEF_MAX_FACTOR
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    gpool_cell_if.sink             cells,
    gpool_result_if.source         pooled,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int FW = $clog2(MAX_FACTOR + 1);

    logic [FW-1:0]       factor;
    logic [WW-1:0]       width;
    logic [HEIGHT_W-1:0] height;
    logic                min_mode;
    pos_flags_t          flags;
    logic [CW-1:0]       blk_col;
    logic [ROW_W-1:0]    blk_row;
    logic                take;

    gpool_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .factor    (factor),
        .width     (width),
        .height    (height),
        .min_mode  (min_mode)
    );

    gpool_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_write),
        .take    (take),
        .factor  (factor),
        .width   (width),
        .height  (height),
        .flags   (flags),
        .blk_col (blk_col),
        .blk_row (blk_row)
    );

    gpool_reduce #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .cells    (cells),
        .pooled   (pooled),
        .min_mode (min_mode),
        .flags    (flags),
        .blk_col  (blk_col),
        .blk_row  (blk_row),
        .take     (take)
    );

    // the final cell of a frame always closes a block and produces a word
    assert property (@(posedge clk) disable iff (!rst_n)
        flags.last |-> (flags.seg_end && flags.block_done))
        else $error("last cell does not close a block");

    // a register write puts the next cell at the frame origin
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (blk_col == '0 && blk_row == '0 && flags.first_col && flags.first_row))
        else $error("frame not restarted after register write");

    // after the last cell is taken the next frame starts at the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && flags.last) |=> (blk_col == '0 && blk_row == '0 && flags.first_row))
        else $error("counters not cleared at end of frame");

endmodule

// ===== rtl/core/gpool_cfg.sv =====
`timescale 1ns / 1ps

module gpool_cfg
    import gpool_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = DEF_MAX_FACTOR,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int FW = $clog2(MAX_FACTOR + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [FW-1:0]          factor,
    output logic [WW-1:0]          width,
    output logic [HEIGHT_W-1:0]    height,
    output logic                   min_mode
);

    localparam int FACTOR_INIT = (FACTOR_RESET > MAX_FACTOR) ? MAX_FACTOR : FACTOR_RESET;
    localparam int WIDTH_INIT  = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    logic [FW-1:0]             factor_reg;
    logic [WW-1:0]             width_reg;
    logic [HEIGHT_W-1:0]       height_reg;
    logic                      min_mode_reg;

    logic [FACTOR_FIELD_W-1:0] f_raw;
    logic [WIDTH_FIELD_W-1:0]  w_raw;
    logic [HEIGHT_W-1:0]       h_raw;
    logic [FW-1:0]             f_clip;
    logic [WW-1:0]             w_clip;
    logic [HEIGHT_W-1:0]       h_clip;

    assign f_raw = cfg_data[FACTOR_FIELD_W-1:0];
    assign w_raw = cfg_data[WIDTH_FIELD_W-1:0];
    assign h_raw = cfg_data[HEIGHT_W-1:0];

    // zero reads as one, oversize saturates
    always_comb
    begin
        if (f_raw == '0)
            f_clip = FW'(1);
        else if (int'(f_raw) > MAX_FACTOR)
            f_clip = FW'(MAX_FACTOR);
        else
            f_clip = FW'(f_raw);

        if (w_raw == '0)
            w_clip = WW'(1);
        else if (int'(w_raw) > MAX_WIDTH)
            w_clip = WW'(MAX_WIDTH);
        else
            w_clip = WW'(w_raw);

        if (h_raw == '0)
            h_clip = HEIGHT_W'(1);
        else
            h_clip = h_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg   <= FW'(FACTOR_INIT);
            width_reg    <= WW'(WIDTH_INIT);
            height_reg   <= HEIGHT_W'(HEIGHT_RESET);
            min_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BLOCK_FACTOR: factor_reg   <= f_clip;
                REG_MAP_WIDTH:    width_reg    <= w_clip;
                REG_MAP_HEIGHT:   height_reg   <= h_clip;
                REG_MIN_MODE:     min_mode_reg <= cfg_data[0];
            endcase
        end
    end

    assign factor   = factor_reg;
    assign width    = width_reg;
    assign height   = height_reg;
    assign min_mode = min_mode_reg;

endmodule

// ===== rtl/core/gpool_pos.sv =====
`timescale 1ns / 1ps

module gpool_pos
    import gpool_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = DEF_MAX_FACTOR,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int SW = $clog2(MAX_FACTOR),
    localparam int FW = $clog2(MAX_FACTOR + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                restart,
    input  logic                take,
    input  logic [FW-1:0]       factor,
    input  logic [WW-1:0]       width,
    input  logic [HEIGHT_W-1:0] height,
    output pos_flags_t          flags,
    output logic [CW-1:0]       blk_col,
    output logic [ROW_W-1:0]    blk_row
);

    logic [CW-1:0]    in_col_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [SW-1:0]    sub_col_reg;
    logic [SW-1:0]    sub_row_reg;
    logic [CW-1:0]    blk_col_reg;
    logic [ROW_W-1:0] blk_row_reg;

    logic [WW:0]      col_inc;
    logic [ROW_W:0]   row_inc;
    logic [FW:0]      sub_col_inc;
    logic [FW:0]      sub_row_inc;
    logic             row_end;
    logic             col_end;
    logic             sub_col_end;
    logic             sub_row_end;

    assign col_inc     = (WW + 1)'(in_col_reg) + (WW + 1)'(1);
    assign row_inc     = (ROW_W + 1)'(in_row_reg) + (ROW_W + 1)'(1);
    assign sub_col_inc = (FW + 1)'(sub_col_reg) + (FW + 1)'(1);
    assign sub_row_inc = (FW + 1)'(sub_row_reg) + (FW + 1)'(1);

    assign row_end     = col_inc >= {1'b0, width};
    assign col_end     = row_inc >= (ROW_W + 1)'(height);
    assign sub_col_end = sub_col_inc >= {1'b0, factor};
    assign sub_row_end = sub_row_inc >= {1'b0, factor};

    always_comb
    begin
        flags.first_col  = (sub_col_reg == '0);
        flags.seg_end    = sub_col_end || row_end;
        flags.first_row  = (sub_row_reg == '0);
        flags.block_done = sub_row_end || col_end;
        flags.last       = row_end && col_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            blk_col_reg <= '0;
            blk_row_reg <= '0;
        end
        else if (restart || (take && row_end && col_end))
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            blk_col_reg <= '0;
            blk_row_reg <= '0;
        end
        else if (take)
        begin
            if (row_end)
            begin
                in_col_reg  <= '0;
                sub_col_reg <= '0;
                blk_col_reg <= '0;
                in_row_reg  <= in_row_reg + ROW_W'(1);
                if (sub_row_end)
                begin
                    sub_row_reg <= '0;
                    blk_row_reg <= blk_row_reg + ROW_W'(1);
                end
                else
                begin
                    sub_row_reg <= sub_row_reg + SW'(1);
                end
            end
            else
            begin
                in_col_reg <= in_col_reg + CW'(1);
                if (sub_col_end)
                begin
                    sub_col_reg <= '0;
                    blk_col_reg <= blk_col_reg + CW'(1);
                end
                else
                begin
                    sub_col_reg <= sub_col_reg + SW'(1);
                end
            end
        end
    end

    assign blk_col = blk_col_reg;
    assign blk_row = blk_row_reg;

endmodule

// ===== rtl/core/gpool_reduce.sv =====
`timescale 1ns / 1ps

module gpool_reduce
    import gpool_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    gpool_cell_if.sink            cells,
    gpool_result_if.source        pooled,
    input  logic                  min_mode,
    input  pos_flags_t            flags,
    input  logic [CW-1:0]         blk_col,
    input  logic [ROW_W-1:0]      blk_row,
    output logic                  take
);

    function automatic logic [COST_W-1:0] pick(
        input logic [COST_W-1:0] a,
        input logic [COST_W-1:0] b,
        input logic              keep_min
    );
        if (keep_min)
            return (a < b) ? a : b;
        return (a > b) ? a : b;
    endfunction

    // partial result of every output column
    logic [COST_W-1:0] line_mem [MAX_WIDTH];

    // work stage
    logic              a_valid_reg;
    logic [COST_W-1:0] a_cost_reg;
    pos_flags_t        a_flags_reg;
    logic [CW-1:0]     a_col_reg;
    logic [ROW_W-1:0]  a_row_reg;
    logic [COST_W-1:0] line_q_reg;
    logic              fwd_reg;
    logic [COST_W-1:0] fwd_data_reg;
    logic [COST_W-1:0] run_reg;

    // result register
    logic              out_valid_reg;
    logic [COST_W-1:0] out_cost_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic              out_last_reg;

    logic [COST_W-1:0] run_next;
    logic [COST_W-1:0] line_val;
    logic [COST_W-1:0] part;
    logic              emit;
    logic              out_free;
    logic              a_adv;
    logic              wr_en;

    assign run_next = a_flags_reg.first_col ? a_cost_reg : pick(run_reg, a_cost_reg, min_mode);
    // a write to the same column in the cycle of the read is taken from the bypass
    assign line_val = fwd_reg ? fwd_data_reg : line_q_reg;
    assign part     = a_flags_reg.first_row ? run_next : pick(line_val, run_next, min_mode);
    assign emit     = a_flags_reg.seg_end && a_flags_reg.block_done;
    assign out_free = !out_valid_reg || pooled.ready;
    assign a_adv    = a_valid_reg && (!emit || out_free);
    assign wr_en    = a_adv && a_flags_reg.seg_end && !a_flags_reg.block_done;

    assign cells.ready = !a_valid_reg || a_adv;
    assign take        = cells.valid && cells.ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[a_col_reg] <= part;
        if (take)
            line_q_reg <= line_mem[blk_col];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                a_valid_reg <= 1'b1;
                fwd_reg     <= wr_en && (a_col_reg == blk_col);
            end
            else if (a_adv)
            begin
                a_valid_reg <= 1'b0;
            end

            if (a_adv && emit)
                out_valid_reg <= 1'b1;
            else if (pooled.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_cost_reg   <= cells.cell_cost;
            a_flags_reg  <= flags;
            a_col_reg    <= blk_col;
            a_row_reg    <= blk_row;
            fwd_data_reg <= part;
        end
        if (a_adv)
            run_reg <= run_next;
        if (a_adv && emit)
        begin
            out_cost_reg <= part;
            out_col_reg  <= COL_W'(a_col_reg);
            out_row_reg  <= a_row_reg;
            out_last_reg <= a_flags_reg.last;
        end
    end

    assign pooled.valid       = out_valid_reg;
    assign pooled.pooled_cost = out_cost_reg;
    assign pooled.out_col     = out_col_reg;
    assign pooled.out_row     = out_row_reg;
    assign pooled.last_cell   = out_last_reg;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import gpool_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_CELLS  = 1100;
    localparam int DIR_ROWS      = 37;
    localparam int EXT_PHASES    = 3;
    localparam int EXT_CELLS     = 300;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              last;
    } pool_result_t;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_RESULT
    } chk_kind_t;

    typedef enum logic {
        ROW_CELL,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        cfg_reg_t              sel;
        logic [CFG_DATA_W-1:0] data;
        logic [COST_W-1:0]     cost;
        chk_kind_t             chk;
        pool_result_t          res;
    } stim_row_t;

    typedef struct packed {
        chk_kind_t    chk;
        pool_result_t res;
    } cell_note_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gpool_cell_if   cells_if();
    gpool_result_if pooled_if();

    grid_block_min_max_pool i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cells     (cells_if),
        .pooled    (pooled_if),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies and pooling state of the predictor
    logic [FACTOR_FIELD_W-1:0] pr_factor;
    logic [WIDTH_FIELD_W-1:0]  pr_width;
    logic [HEIGHT_W-1:0]       pr_height;
    logic                      pr_min;

    logic [COST_W-1:0] line_partial [DEF_MAX_WIDTH];
    logic [COST_W-1:0] block_acc;
    logic [COL_W-1:0]  in_col;
    logic [ROW_W-1:0]  in_row;
    logic [3:0]        sub_col;
    logic [3:0]        sub_row;
    logic [COL_W-1:0]  blk_col;
    logic [ROW_W-1:0]  blk_row;

    pool_result_t pooled_q [$];
    cell_note_t   cell_note_q [$];
    bit           fail_seen;
    bit           idle_on;
    int unsigned  cycle_cnt;

    cell_note_t   cur_note;
    pool_result_t pred_res;
    pool_result_t want;
    bit           has_pred;

    stim_row_t stim_tab [DIR_ROWS] = '{
        // partial frame under the reset settings, then restarted by the writes
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'hFF, CHK_NONE,   '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h00, CHK_NONE,   '0},
        // zero factor acts as 1: every cell is its own block
        '{ROW_WRITE, REG_BLOCK_FACTOR, 16'h0000, 8'h00, CHK_NONE,   '0},
        '{ROW_WRITE, REG_MAP_WIDTH,    16'h0002, 8'h00, CHK_NONE,   '0},
        '{ROW_WRITE, REG_MAP_HEIGHT,   16'h0001, 8'h00, CHK_NONE,   '0},
        '{ROW_WRITE, REG_MIN_MODE,     16'h0001, 8'h00, CHK_NONE,   '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h00, CHK_RESULT,
          '{8'h00, 12'd0, 16'd0, 1'b0}},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'hFF, CHK_RESULT,
          '{8'hFF, 12'd1, 16'd0, 1'b1}},
        // next frame starts right after the last cell
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h5A, CHK_RESULT,
          '{8'h5A, 12'd0, 16'd0, 1'b0}},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'hA5, CHK_RESULT,
          '{8'hA5, 12'd1, 16'd0, 1'b1}},
        // factor saturates at 16, one clipped 3x2 block, max mode
        '{ROW_WRITE, REG_BLOCK_FACTOR, 16'hFFFF, 8'h00, CHK_NONE,   '0},
        '{ROW_WRITE, REG_MAP_WIDTH,    16'h0003, 8'h00, CHK_NONE,   '0},
        '{ROW_WRITE, REG_MAP_HEIGHT,   16'h0002, 8'h00, CHK_NONE,   '0},
        '{ROW_WRITE, REG_MIN_MODE,     16'hFFFE, 8'h00, CHK_NONE,   '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h10, CHK_NONE,   '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'hFF, CHK_NONE,   '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h07, CHK_NONE,   '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h00, CHK_NONE,   '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h01, CHK_NONE,   '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h02, CHK_RESULT,
          '{8'hFF, 12'd0, 16'd0, 1'b1}},
        // zero width and height act as 1
        '{ROW_WRITE, REG_MAP_WIDTH,    16'h0000, 8'h00, CHK_NONE,   '0},
        '{ROW_WRITE, REG_MAP_HEIGHT,   16'h0000, 8'h00, CHK_NONE,   '0},
        '{ROW_WRITE, REG_MIN_MODE,     16'h0001, 8'h00, CHK_NONE,   '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'hC8, CHK_RESULT,
          '{8'hC8, 12'd0, 16'd0, 1'b1}},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h00, CHK_RESULT,
          '{8'h00, 12'd0, 16'd0, 1'b1}},
        // blocks clipped on the right and at the bottom
        '{ROW_WRITE, REG_BLOCK_FACTOR, 16'h0002, 8'h00, CHK_NONE,   '0},
        '{ROW_WRITE, REG_MAP_WIDTH,    16'h0003, 8'h00, CHK_NONE,   '0},
        '{ROW_WRITE, REG_MAP_HEIGHT,   16'h0003, 8'h00, CHK_NONE,   '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h40, CHK_MODEL,  '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h20, CHK_MODEL,  '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h90, CHK_MODEL,  '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h10, CHK_MODEL,  '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h80, CHK_MODEL,  '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h30, CHK_MODEL,  '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h70, CHK_MODEL,  '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h60, CHK_MODEL,  '0},
        '{ROW_CELL,  REG_BLOCK_FACTOR, 16'h0000, 8'h50, CHK_MODEL,  '0}
    };

    // extreme settings at the end, only the first cells of each frame:
    // full row width, largest factor, tallest map
    logic [CFG_DATA_W-1:0] ext_factor [EXT_PHASES] = '{16'h0021, 16'hFFFF, 16'h0001};
    logic [CFG_DATA_W-1:0] ext_width  [EXT_PHASES] = '{16'hF000, 16'hFFFF, 16'h0001};
    logic [CFG_DATA_W-1:0] ext_height [EXT_PHASES] = '{16'h0002, 16'h0001, 16'hFFFF};
    logic [CFG_DATA_W-1:0] ext_min    [EXT_PHASES] = '{16'h0001, 16'h0000, 16'h0001};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int eff_width(input logic [WIDTH_FIELD_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > DEF_MAX_WIDTH)
            return DEF_MAX_WIDTH;
        return int'(w);
    endfunction

    function automatic int eff_height(input logic [HEIGHT_W-1:0] h);
        if (h == 0)
            return 1;
        return int'(h);
    endfunction

    function automatic logic [COST_W-1:0] fold_cost(input logic [COST_W-1:0] a,
                                                    input logic [COST_W-1:0] b);
        if (pr_min)
            return (a < b) ? a : b;
        return (a > b) ? a : b;
    endfunction

    function automatic void rewind_frame();
        block_acc = '0;
        in_col    = '0;
        in_row    = '0;
        sub_col   = '0;
        sub_row   = '0;
        blk_col   = '0;
        blk_row   = '0;
    endfunction

    function automatic void load_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] data);
        case (sel)
            REG_BLOCK_FACTOR: pr_factor = data[FACTOR_FIELD_W-1:0];
            REG_MAP_WIDTH:    pr_width  = data[WIDTH_FIELD_W-1:0];
            REG_MAP_HEIGHT:   pr_height = data[HEIGHT_W-1:0];
            REG_MIN_MODE:     pr_min    = data[0];
        endcase
        rewind_frame();
    endfunction

    // folds one cell into the running block and the line store; 1 when a block closes
    function automatic bit pool_cell(input logic [COST_W-1:0] cost, output pool_result_t res);
        int                f;
        int                w;
        int                h;
        logic [COST_W-1:0] part;
        bit                row_end;
        bit                col_end;
        bit                emit;

        f = (pr_factor == 0) ? 1 : int'(pr_factor);
        if (f > DEF_MAX_FACTOR)
            f = DEF_MAX_FACTOR;
        w    = eff_width(pr_width);
        h    = eff_height(pr_height);
        emit = 1'b0;
        res  = '0;

        block_acc = (sub_col == 0) ? cost : fold_cost(block_acc, cost);
        row_end   = (in_col + 1 >= w);
        col_end   = (in_row + 1 >= h);

        if (sub_col + 1 >= f || row_end)
        begin
            part = (sub_row == 0) ? block_acc : fold_cost(line_partial[blk_col], block_acc);
            if (sub_row + 1 >= f || col_end)
            begin
                res.cost = part;
                res.col  = blk_col;
                res.row  = blk_row;
                res.last = row_end && col_end;
                emit     = 1'b1;
            end
            else
            begin
                line_partial[blk_col] = part;
            end
        end

        if (row_end)
        begin
            in_col  = '0;
            sub_col = '0;
            blk_col = '0;
            if (col_end)
            begin
                rewind_frame();
            end
            else
            begin
                in_row++;
                if (sub_row + 1 >= f)
                begin
                    sub_row = '0;
                    blk_row++;
                end
                else
                begin
                    sub_row++;
                end
            end
        end
        else
        begin
            in_col++;
            if (sub_col + 1 >= f)
            begin
                sub_col = '0;
                blk_col++;
            end
            else
            begin
                sub_col++;
            end
        end
        return emit;
    endfunction

    function automatic logic [COST_W-1:0] pick_cost();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return COST_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            fail_seen = 1'b1;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_val,
                     act_val);
        end
    endtask

    // one word per cell; valid stays high across back-to-back words
    task automatic push_cell(input logic [COST_W-1:0] cost, input chk_kind_t chk,
                             input pool_result_t res);
        cell_note_t note;

        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            cells_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        cells_if.valid     <= 1'b1;
        cells_if.cell_cost <= cost;
        note.chk = chk;
        note.res = res;
        cell_note_q.push_back(note);
        do
            @(posedge clk);
        while (!cells_if.ready);
        @(negedge clk);
    endtask

    // writes only once the block has gone quiet
    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] data);
        cells_if.valid <= 1'b0;
        while (pooled_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        load_reg(sel, data);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        pooled_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 9) == 0)
            begin
                pooled_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            pooled_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (cells_if.valid && cells_if.ready)
        begin
            cur_note = cell_note_q.pop_front();
            has_pred = pool_cell(cells_if.cell_cost, pred_res);
            if (cur_note.chk == CHK_MODEL)
            begin
                if (has_pred)
                    pooled_q.push_back(pred_res);
            end
            else if (cur_note.chk == CHK_RESULT)
            begin
                pooled_q.push_back(cur_note.res);
            end
        end

        if (pooled_if.valid && pooled_if.ready)
        begin
            if (pooled_q.size() == 0)
            begin
                fail_seen = 1'b1;
                $display("%0t: unexpected word: expected none, actual %0h %0d %0d %0b",
                         $time, pooled_if.pooled_cost, pooled_if.out_col, pooled_if.out_row,
                         pooled_if.last_cell);
            end
            else
            begin
                want = pooled_q.pop_front();
                check_field("pooled_cost", 32'(want.cost), 32'(pooled_if.pooled_cost));
                check_field("out_col", 32'(want.col), 32'(pooled_if.out_col));
                check_field("out_row", 32'(want.row), 32'(pooled_if.out_row));
                check_field("last_cell", 32'(want.last), 32'(pooled_if.last_cell));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned           n;
        int unsigned           done_cells;
        logic [4:0]            fdat;
        logic [12:0]           wdat;
        logic [CFG_DATA_W-1:0] hdat;
        logic [CFG_DATA_W-1:0] junk;

        rst_n              = 1'b0;
        cells_if.valid     = 1'b0;
        cells_if.cell_cost = '0;
        cfg_write          = 1'b0;
        cfg_index          = REG_BLOCK_FACTOR;
        cfg_data           = '0;
        fail_seen          = 1'b0;
        cycle_cnt          = 0;
        idle_on            = 1'b1;
        pr_factor          = FACTOR_FIELD_W'(FACTOR_RESET);
        pr_width           = WIDTH_FIELD_W'(WIDTH_RESET);
        pr_height          = HEIGHT_W'(HEIGHT_RESET);
        pr_min             = 1'b0;
        rewind_frame();

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (stim_tab[i].kind == ROW_WRITE)
                write_reg(stim_tab[i].sel, stim_tab[i].data);
            else
                push_cell(stim_tab[i].cost, stim_tab[i].chk, stim_tab[i].res);
        end

        done_cells = 0;
        while (done_cells < RANDOM_CELLS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       fdat = FACTOR_FIELD_W'(0);
                1:       fdat = FACTOR_FIELD_W'(DEF_MAX_FACTOR);
                2:       fdat = FACTOR_FIELD_W'($urandom_range(DEF_MAX_FACTOR + 1, 31));
                default: fdat = FACTOR_FIELD_W'($urandom_range(1, 6));
            endcase
            wdat = ($urandom_range(0, 7) == 0) ? WIDTH_FIELD_W'($urandom_range(0, 1))
                                               : WIDTH_FIELD_W'($urandom_range(2, 24));
            hdat = ($urandom_range(0, 7) == 0) ? HEIGHT_W'($urandom_range(0, 1))
                                               : HEIGHT_W'($urandom_range(2, 24));

            // bits above each field must be ignored
            junk = CFG_DATA_W'($urandom);
            write_reg(REG_BLOCK_FACTOR, {junk[CFG_DATA_W-1:FACTOR_FIELD_W], fdat});
            junk = CFG_DATA_W'($urandom);
            write_reg(REG_MAP_WIDTH, {junk[CFG_DATA_W-1:WIDTH_FIELD_W], wdat});
            write_reg(REG_MAP_HEIGHT, hdat);
            junk = CFG_DATA_W'($urandom);
            write_reg(REG_MIN_MODE, junk);

            n = eff_width(pr_width) * eff_height(pr_height);
            case ($urandom_range(0, 4))
                0:       n = $urandom_range(1, n);
                1:       n = 2 * n;
                default: ;
            endcase
            for (int k = 0; k < n; k++)
                push_cell(pick_cost(), CHK_MODEL, '0);
            done_cells += n;
        end

        idle_on = 1'b0;
        for (int p = 0; p < EXT_PHASES; p++)
        begin
            write_reg(REG_BLOCK_FACTOR, ext_factor[p]);
            write_reg(REG_MAP_WIDTH, ext_width[p]);
            write_reg(REG_MAP_HEIGHT, ext_height[p]);
            write_reg(REG_MIN_MODE, ext_min[p]);
            n = eff_width(pr_width) * eff_height(pr_height);
            if (n > EXT_CELLS)
                n = EXT_CELLS;
            for (int k = 0; k < n; k++)
                push_cell(pick_cost(), CHK_MODEL, '0);
        end

        cells_if.valid <= 1'b0;
        while (pooled_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (!fail_seen)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
